### sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants
// Round constants, initial hash values and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } sha_word_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = 2;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### sv/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue: input word queue
// Small FIFO that decouples word intake from block processing.
// ----------------------------------------------------------------------------
module sha_queue import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  sha_word_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output sha_word_t rd_data
);

  sha_word_t      mem_r [QDepth];
  logic [QAw-1:0] wp_r, rp_r;
  logic [QAw:0]   cnt_r;

  assign wr_ready = (cnt_r != QAw'(0) + (QAw+1)'(QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= wp_r + 1'b1;
      if (rd_valid && rd_ready) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAw+1)'(wr_valid && wr_ready) - (QAw+1)'(rd_valid && rd_ready);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAw+1)'(QDepth)) else $error("queue count over depth");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (QAw+1)'(QDepth)) |-> !wr_ready) else $error("queue full not flagged");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !rd_valid) else $error("read from empty queue");

endmodule

### sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core: block gathering, padding and compression
// Takes queued words, fills the block, pads at end of message, runs 64
// rounds one per cycle and emits digest words from the hash state, or an overflow error.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  sha_word_t   q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_overflow_error
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_ERR  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [60:0] total_r;
  logic [5:0]  fill_r;
  logic        ovf_r;
  logic [5:0]  t_r;
  logic        final_r;
  logic        mark_r;
  logic        pad_done_r;
  logic [2:0]  oi_r;

  logic        take;
  logic        add_byte;
  logic        len_word;
  logic [31:0] w_new, w15, w2, s0, s1, t1, t2;
  logic [31:0] e, a;
  logic [63:0] bits;
  logic [31:0] keep_mask, mark_word;

  assign q_ready = (st_r == S_IDLE) && !(out_valid && !out_ready);
  assign take = q_valid && q_ready;
  assign add_byte = take && q_data.has_byte && !ovf_r && (total_r != '1);
  assign bits = {total_r, 3'b000};
  assign len_word = mark_r || (fill_r <= 6'd55);

  always_comb begin
    case (fill_r[1:0])
      2'd0: begin
        keep_mask = 32'h00000000;
        mark_word = 32'h80000000;
      end
      2'd1: begin
        keep_mask = 32'hff000000;
        mark_word = 32'h00800000;
      end
      2'd2: begin
        keep_mask = 32'hffff0000;
        mark_word = 32'h00008000;
      end
      default: begin
        keep_mask = 32'hffffff00;
        mark_word = 32'h00000080;
      end
    endcase
  end

  assign w15 = w_r[4'(t_r - 6'd15)];
  assign w2  = w_r[4'(t_r - 6'd2)];
  assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  always_comb begin
    if (t_r < 6'd16) begin
      w_new = w_r[t_r[3:0]];
    end else begin
      w_new = w_r[t_r[3:0]] + s0 + w_r[4'(t_r - 6'd7)] + s1;
    end
  end
  assign e  = v_r[4];
  assign a  = v_r[0];
  assign t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
              ((e & v_r[5]) ^ (~e & v_r[6])) + RoundK[t_r] + w_new;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
              ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (take) begin
          if (add_byte && fill_r == 6'd63) st_nxt = S_RND;
          else if (q_data.eom && (ovf_r || (q_data.has_byte && total_r == '1)))
            st_nxt = S_ERR;
          else if (q_data.eom) st_nxt = S_PAD;
        end
      end
      S_PAD:  st_nxt = S_RND;
      S_RND:  if (t_r == 6'd63) st_nxt = S_ADD;
      S_ADD: begin
        if (!final_r) st_nxt = S_IDLE;
        else if (!pad_done_r) st_nxt = S_PAD;
        else st_nxt = S_OUT;
      end
      S_OUT:  if (out_ready && oi_r == 3'd7) st_nxt = S_IDLE;
      S_ERR:  if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (add_byte) w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= q_data.data;
    if (st_r == S_PAD) begin
      for (int i = 0; i < 16; i++) begin
        if (len_word && i == 14) begin
          w_r[i] <= bits[63:32];
        end else if (len_word && i == 15) begin
          w_r[i] <= bits[31:0];
        end else if (mark_r || 4'(i) > fill_r[5:2]) begin
          w_r[i] <= 32'h0;
        end else if (4'(i) == fill_r[5:2]) begin
          w_r[i] <= (w_r[i] & keep_mask) | mark_word;
        end
      end
    end
    if (st_r == S_RND) begin
      w_r[t_r[3:0]] <= w_new;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      total_r    <= '0;
      fill_r     <= '0;
      ovf_r      <= 1'b0;
      t_r        <= '0;
      final_r    <= 1'b0;
      mark_r     <= 1'b0;
      pad_done_r <= 1'b0;
      oi_r       <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: begin
          if (take && q_data.has_byte && !ovf_r && total_r == '1) ovf_r <= 1'b1;
          if (add_byte) begin
            total_r <= total_r + 61'd1;
            fill_r  <= fill_r + 6'd1;
          end
          if (take && q_data.eom) final_r <= 1'b1;
          mark_r <= 1'b0;
          pad_done_r <= 1'b0;
          t_r <= '0;
        end
        S_PAD: begin
          mark_r     <= 1'b1;
          pad_done_r <= len_word;
        end
        S_RND: t_r <= t_r + 6'd1;
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          t_r <= '0;
          oi_r <= '0;
        end
        S_OUT: begin
          if (out_ready) begin
            oi_r <= oi_r + 3'd1;
            if (oi_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
              total_r <= '0; fill_r <= '0; ovf_r <= 1'b0; final_r <= 1'b0;
            end
          end
        end
        S_ERR: begin
          if (out_ready) begin
            for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
            total_r <= '0; fill_r <= '0; ovf_r <= 1'b0; final_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = (st_r == S_OUT) || (st_r == S_ERR);
  assign out_digest_word    = (st_r == S_OUT) ? h_r[oi_r] : 32'd0;
  assign out_word_index     = (st_r == S_OUT) ? oi_r : 3'd0;
  assign out_last_word      = (st_r == S_ERR) || (oi_r == 3'd7);
  assign out_overflow_error = (st_r == S_ERR);

  a_rnd_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RND && t_r != 6'd63) |=> (st_r == S_RND)) else $error("round cut short");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !q_ready) else $error("intake while busy");
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ERR && out_ready) |=> (st_r == S_IDLE)) else $error("error result repeated");

endmodule

### sv/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit: streaming SHA-256 hasher
// Queue front end feeding a round-per-cycle compression back end.
//
//   channel | ports                                      | direction
//   in      | in_valid/in_ready, data_byte, has_byte, eom | sink
//   out     | out_valid/out_ready, digest, index, last, err | source
//
// A byte is taken from the queue only while the core is idle; a full block
// then runs 64 rounds and an add in the single shared round unit. End of
// message adds one or two padded blocks (pad, 64 rounds, add), then eight
// digest words, one per out handshake.
// Reset (rst_n low, synchronous) restores the initial hash.
// The queue keeps accepting while the back end is busy until it is full.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_overflow_error
);

  sha_word_t wr_data, rd_data;
  logic      rd_valid, rd_ready;

  assign wr_data = '{data: in_data_byte, has_byte: in_has_byte, eom: in_end_of_message};

  sha_queue u_queue (
    .clk, .rst_n,
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data,
    .rd_valid, .rd_ready, .rd_data
  );

  sha_core u_core (
    .clk, .rst_n,
    .q_valid(rd_valid), .q_ready(rd_ready), .q_data(rd_data),
    .out_valid, .out_ready, .out_digest_word, .out_word_index,
    .out_last_word, .out_overflow_error
  );

endmodule
